/* rtl/tsiw_pkg.sv */
// ----------------------------------------------------------------------------
// tsiw_pkg
// Shared types, geometry and code values of the text screen writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tsiw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // Field widths
    localparam int ADDR_W = 11;
    localparam int CODE_W = 9;
    localparam int CELL_W = 16;
    localparam int BYTE_W = 8;
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLUMNS);

    localparam logic [ADDR_W-1:0] NUM_CELLS = ADDR_W'(CELLS);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] SCR_BOUND = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] SCR_COUNT = ADDR_W'((ROWS - 2) * COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_CELLS = ADDR_W'(COLUMNS);
    localparam logic [ROW_W-1:0]  BOT_ROW   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [COL_W-1:0]  COL_THREE = COL_W'(3);

    // Request codes
    localparam logic [CODE_W-1:0] CODE_NL   = CODE_W'(10);
    localparam logic [CODE_W-1:0] CODE_BS   = CODE_W'(256);
    localparam logic [CODE_W-1:0] CODE_BACK = CODE_W'(257);
    localparam logic [CODE_W-1:0] CODE_FWD  = CODE_W'(258);
    localparam logic [CODE_W-1:0] CODE_CLR  = CODE_W'(259);
    localparam logic [CODE_W-1:0] CODE_COL3 = CODE_W'(260);

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [BYTE_W-1:0] ECHO_BS    = BYTE_W'(8);
    localparam logic [BYTE_W-1:0] ECHO_SPACE = BYTE_W'(32);
    localparam logic [CELL_W-1:0] BLANK_CELL = CELL_W'(16'h0020);
    localparam logic [BYTE_W-1:0] ATTR_RESET = BYTE_W'(7);

    // Sweep modes
    localparam logic [1:0] SW_CLR = 2'd0;  // write zero, ascending
    localparam logic [1:0] SW_DEL = 2'd1;  // move down by one, ascending
    localparam logic [1:0] SW_SCR = 2'd2;  // move down by a row, ascending
    localparam logic [1:0] SW_INS = 2'd3;  // move up by one, descending

    // Cursor operations
    localparam logic [2:0] CUR_NONE = 3'd0;
    localparam logic [2:0] CUR_DEC  = 3'd1;
    localparam logic [2:0] CUR_INC  = 3'd2;  // stops at last cell
    localparam logic [2:0] CUR_INCR = 3'd3;  // may run past the last cell
    localparam logic [2:0] CUR_NL   = 3'd4;
    localparam logic [2:0] CUR_COL3 = 3'd5;
    localparam logic [2:0] CUR_SCRL = 3'd6;

    // Result kinds
    localparam logic [2:0] EM_NONE  = 3'd0;
    localparam logic [2:0] EM_BYTE  = 3'd1;
    localparam logic [2:0] EM_BS0   = 3'd2;
    localparam logic [2:0] EM_BS1   = 3'd3;
    localparam logic [2:0] EM_BS2   = 3'd4;
    localparam logic [2:0] EM_READ  = 3'd5;
    localparam logic [2:0] EM_READ0 = 3'd6;

    typedef struct packed {
        logic              req_type;
        logic [CODE_W-1:0] code;
        logic [ADDR_W-1:0] cell_addr;
    } t_in;

    typedef struct packed {
        logic              serial_valid;
        logic [BYTE_W-1:0] serial_byte;
        logic [ADDR_W-1:0] cursor_now;
        logic [CELL_W-1:0] cell_value;
        logic              last;
    } t_out;

    typedef struct packed {
        logic              accept;
        logic              sw_go;
        logic [1:0]        sw_mode;
        logic [ADDR_W-1:0] sw_start;
        logic [ADDR_W-1:0] sw_count;
        logic              poke;
        logic              poke_blank;
        logic              peek;
        logic [2:0]        cur_op;
        logic              emit;
        logic [2:0]        emit_kind;
    } t_cmd;

    typedef struct packed {
        logic              busy;
        logic              out_free;
        t_in               req;
        logic [ROW_W-1:0]  row;
        logic [ADDR_W-1:0] pos;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/tsiw_dpath.sv */
// ----------------------------------------------------------------------------
// tsiw_dpath
// Cell store, sweep engine, cursor, request and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tsiw_dpath import tsiw_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire t_in               i_in_data,
    input  wire logic              i_cfg_we,
    input  wire logic [BYTE_W-1:0] i_cfg_wdata,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output t_out                   o_out_data,
    output t_sts                   o_sts
);

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rd_data;
    t_in               r_req;
    logic [BYTE_W-1:0] r_attr;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [1:0]        r_sw_mode;
    logic [ADDR_W-1:0] r_sw_addr, r_sw_left;
    logic              r_wv;
    logic [ADDR_W-1:0] r_wa, n_wa;
    logic              r_ovalid;
    t_out              r_odata, n_odata;

    logic              sw_act, w_en, rd_en;
    logic [ADDR_W-1:0] w_addr, rd_addr, pos;
    logic [CELL_W-1:0] w_data;

    assign pos    = ADDR_W'(r_row * COLUMNS) + ADDR_W'(r_col);
    assign sw_act = (r_sw_left != '0);

    // Write port: pending move, then clear sweep, then single write
    always_comb begin
        w_en   = 1'b0;
        w_addr = pos;
        w_data = '0;
        if (r_wv) begin
            w_en   = 1'b1;
            w_addr = r_wa;
            w_data = r_rd_data;
        end else if (sw_act && r_sw_mode == SW_CLR) begin
            w_en   = 1'b1;
            w_addr = r_sw_addr;
        end else if (i_cmd.poke) begin
            w_en   = 1'b1;
            w_data = i_cmd.poke_blank ? BLANK_CELL : {r_attr, r_req.code[BYTE_W-1:0]};
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_req.cell_addr;
        if (sw_act && r_sw_mode != SW_CLR) begin
            rd_en   = 1'b1;
            rd_addr = r_sw_addr;
        end else if (i_cmd.peek) begin
            rd_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_comb begin
        case (r_sw_mode)
            SW_DEL:  n_wa = r_sw_addr - ADDR_W'(1);
            SW_SCR:  n_wa = r_sw_addr - ROW_CELLS;
            default: n_wa = r_sw_addr + ADDR_W'(1);
        endcase
    end

    // Sweep engine: read one cell a cycle and write it back in the next cycle; a clear sweep writes zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_left <= '0;
            r_wv      <= 1'b0;
        end else if (i_cmd.sw_go) begin
            r_sw_mode <= i_cmd.sw_mode;
            r_sw_addr <= i_cmd.sw_start;
            r_sw_left <= i_cmd.sw_count;
            r_wv      <= 1'b0;
        end else begin
            r_wv <= sw_act && r_sw_mode != SW_CLR;
            if (sw_act) begin
                r_wa      <= n_wa;
                r_sw_left <= r_sw_left - ADDR_W'(1);
                r_sw_addr <= (r_sw_mode == SW_INS) ? r_sw_addr - ADDR_W'(1)
                                                   : r_sw_addr + ADDR_W'(1);
            end
        end
    end

    // Cursor
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        unique case (i_cmd.cur_op)
            CUR_DEC: begin
                if (r_col != '0) begin
                    n_col = r_col - COL_W'(1);
                end else if (r_row != '0) begin
                    n_row = r_row - ROW_W'(1);
                    n_col = LAST_COL;
                end
            end
            CUR_INC, CUR_INCR: begin
                if (i_cmd.cur_op == CUR_INCR || pos != LAST_CELL) begin
                    if (r_col == LAST_COL) begin
                        n_row = r_row + ROW_W'(1);
                        n_col = '0;
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                end
            end
            CUR_NL: begin
                n_row = r_row + ROW_W'(1);
                n_col = '0;
            end
            CUR_COL3: n_col = COL_THREE;
            CUR_SCRL: begin
                if (r_row != '0) begin
                    n_row = r_row - ROW_W'(1);
                end else begin
                    n_col = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_attr <= ATTR_RESET;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_in_data;
        end
    end

    // Result register
    always_comb begin
        n_odata            = '0;
        n_odata.cursor_now = pos;
        n_odata.last       = 1'b1;
        case (i_cmd.emit_kind)
            EM_BYTE: begin
                n_odata.serial_valid = 1'b1;
                n_odata.serial_byte  = r_req.code[BYTE_W-1:0];
            end
            EM_BS0, EM_BS2: begin
                n_odata.serial_valid = 1'b1;
                n_odata.serial_byte  = ECHO_BS;
                n_odata.last         = (i_cmd.emit_kind == EM_BS2);
            end
            EM_BS1: begin
                n_odata.serial_valid = 1'b1;
                n_odata.serial_byte  = ECHO_SPACE;
                n_odata.last         = 1'b0;
            end
            EM_READ: n_odata.cell_value = r_rd_data;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_odata <= n_odata;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_out_data     = r_odata;
    assign o_sts.busy     = sw_act | r_wv;
    assign o_sts.out_free = !r_ovalid | i_out_ready;
    assign o_sts.req      = r_req;
    assign o_sts.row      = r_row;
    assign o_sts.pos      = pos;

endmodule

`default_nettype wire

/* rtl/tsiw_ctrl.sv */
// ----------------------------------------------------------------------------
// tsiw_ctrl
// Sequencer: decodes a request and steps the datapath through it.
// ----------------------------------------------------------------------------
`default_nettype none

module tsiw_ctrl import tsiw_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_INIT_W = 4'd1;
    localparam logic [3:0] S_IDLE   = 4'd2;
    localparam logic [3:0] S_DEC    = 4'd3;
    localparam logic [3:0] S_INS_W  = 4'd4;
    localparam logic [3:0] S_BS     = 4'd5;
    localparam logic [3:0] S_BS_W   = 4'd6;
    localparam logic [3:0] S_CHECK  = 4'd7;
    localparam logic [3:0] S_CA     = 4'd8;
    localparam logic [3:0] S_SC_MV  = 4'd9;
    localparam logic [3:0] S_SC_MW  = 4'd10;
    localparam logic [3:0] S_SC_Z   = 4'd11;
    localparam logic [3:0] S_SC_ZW  = 4'd12;
    localparam logic [3:0] S_EMIT   = 4'd13;

    logic [3:0] r_state, n_state;
    logic       r_ret_ca, n_ret_ca;
    logic [1:0] r_idx, n_idx;
    logic [3:0] ret_state;
    logic       is_read, addr_ok;
    logic [2:0] kind;

    assign is_read   = (i_sts.req.req_type == REQ_READ);
    assign addr_ok   = (i_sts.req.cell_addr < NUM_CELLS);
    assign ret_state = r_ret_ca ? S_CA : S_EMIT;

    always_comb begin
        if (is_read) begin
            kind = addr_ok ? EM_READ : EM_READ0;
        end else if (i_sts.req.code < CODE_BS) begin
            kind = EM_BYTE;
        end else if (i_sts.req.code == CODE_BS) begin
            case (r_idx)
                2'd0:    kind = EM_BS0;
                2'd1:    kind = EM_BS1;
                default: kind = EM_BS2;
            endcase
        end else begin
            kind = EM_NONE;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_ret_ca         = r_ret_ca;
        n_idx            = r_idx;
        o_cmd            = '0;
        o_cmd.emit_kind  = kind;
        o_in_ready       = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.sw_go    = 1'b1;
                o_cmd.sw_mode  = SW_CLR;
                o_cmd.sw_count = NUM_CELLS;
                n_state        = S_INIT_W;
            end
            S_INIT_W: if (!i_sts.busy) n_state = S_IDLE;
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                n_idx        = '0;
                n_ret_ca     = 1'b0;
                if (i_in_valid) n_state = S_DEC;
            end
            S_DEC: begin
                n_state = S_CHECK;
                if (is_read) begin
                    o_cmd.peek = addr_ok;
                    n_state    = S_EMIT;
                end else begin
                    unique case (i_sts.req.code) inside
                        CODE_NL:   o_cmd.cur_op = CUR_NL;
                        CODE_BACK: o_cmd.cur_op = CUR_DEC;
                        CODE_FWD:  o_cmd.cur_op = CUR_INC;
                        CODE_COL3: o_cmd.cur_op = CUR_COL3;
                        CODE_CLR: begin
                            o_cmd.cur_op = CUR_INC;
                            n_state      = S_CA;
                        end
                        CODE_BS: begin
                            o_cmd.cur_op = CUR_DEC;
                            n_state      = S_BS;
                        end
                        [CODE_W'(0):CODE_W'(9)], [CODE_W'(11):CODE_W'(255)]: begin
                            o_cmd.sw_go    = 1'b1;
                            o_cmd.sw_mode  = SW_INS;
                            o_cmd.sw_start = LAST_CELL - ADDR_W'(1);
                            o_cmd.sw_count = LAST_CELL - i_sts.pos;
                            n_state        = S_INS_W;
                        end
                        default: n_state = S_EMIT;
                    endcase
                end
            end
            S_INS_W: begin
                if (!i_sts.busy) begin
                    o_cmd.poke   = 1'b1;
                    o_cmd.cur_op = CUR_INCR;
                    n_state      = S_CHECK;
                end
            end
            S_BS: begin
                // blank at the cursor first; the shift overwrites it unless last cell
                o_cmd.poke       = 1'b1;
                o_cmd.poke_blank = 1'b1;
                o_cmd.sw_go      = 1'b1;
                o_cmd.sw_mode    = SW_DEL;
                o_cmd.sw_start   = i_sts.pos + ADDR_W'(1);
                o_cmd.sw_count   = LAST_CELL - i_sts.pos;
                n_state          = S_BS_W;
            end
            S_BS_W: if (!i_sts.busy) n_state = S_CHECK;
            S_CHECK: begin
                if (i_sts.row >= BOT_ROW) begin
                    n_ret_ca = 1'b0;
                    n_state  = S_SC_MV;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_CA: begin
                if (i_sts.row != '0) begin
                    n_ret_ca = 1'b1;
                    n_state  = S_SC_MV;
                end else begin
                    o_cmd.cur_op = CUR_DEC;
                    n_ret_ca     = 1'b0;
                    n_state      = S_CHECK;
                end
            end
            S_SC_MV: begin
                o_cmd.sw_go    = 1'b1;
                o_cmd.sw_mode  = SW_SCR;
                o_cmd.sw_start = ROW_CELLS;
                o_cmd.sw_count = SCR_COUNT;
                o_cmd.cur_op   = CUR_SCRL;
                n_state        = S_SC_MW;
            end
            S_SC_MW: if (!i_sts.busy) n_state = S_SC_Z;
            S_SC_Z: begin
                if (i_sts.pos < SCR_BOUND) begin
                    o_cmd.sw_go    = 1'b1;
                    o_cmd.sw_mode  = SW_CLR;
                    o_cmd.sw_start = i_sts.pos;
                    o_cmd.sw_count = SCR_BOUND - i_sts.pos;
                    n_state        = S_SC_ZW;
                end else begin
                    n_state = ret_state;
                end
            end
            S_SC_ZW: if (!i_sts.busy) n_state = ret_state;
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_idx      = r_idx + 2'd1;
                    if (kind != EM_BS0 && kind != EM_BS1) n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ret_ca <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_ret_ca <= n_ret_ca;
            r_idx    <= n_idx;
        end
    end

endmodule

`default_nettype wire

/* rtl/text_screen_insert_writer_core.sv */
// ----------------------------------------------------------------------------
// text_screen_insert_writer_core
// Text-mode screen engine with insert, delete, cursor moves and scrolling.
// ----------------------------------------------------------------------------
// The block keeps a COLUMNS x ROWS store of 16-bit cells (attribute high,
// character low) in a single memory with one read and one write per cycle,
// and every multi-cell operation is a sweep through that memory at one cell
// per cycle. After reset the memory is cleared in one sweep, during which
// no item is accepted; configuration writes are taken at any time. A read
// and a pure cursor move use no sweep; an insert shifts the cells from the
// cursor on up by one and a backspace shifts the cells behind it down by
// one; any put that leaves the cursor on the bottom row adds one scroll of
// (ROWS-2)*COLUMNS moved cells plus up to COLUMNS cleared cells; clear-all
// runs one scroll per row above the cursor. Each put returns its echo items
// (three for backspace) with the final cursor.
// The next item is taken while the last result still waits in the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module text_screen_insert_writer_core import tsiw_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in               i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out                   o_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic [BYTE_W-1:0] i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer: owns the handshake on the input side
    tsiw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Store, cursor and result register
    tsiw_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire

/* rtl/tsiw_checker.sv */
// ----------------------------------------------------------------------------
// tsiw_checker
// Port-level checks of the text screen writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tsiw_checker import tsiw_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_out o_out_data
);

    // Hold off requests while the store clears after reset
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_ready)
        else $error("input ready right after reset");

    // One item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken back to back");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result dropped or changed while stalled");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.cursor_now < NUM_CELLS))
        else $error("cursor out of range");

endmodule

bind text_screen_insert_writer_core tsiw_checker u_tsiw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
